// ===== sv/avlm_pkg.sv =====
// Shared types and constants for the averaged level bar meter.
package avlm_pkg;

  localparam int WIN_LEN     = 10;
  localparam int WIN_IDX_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int SAMPLE_W    = 10;
  localparam int SUM_W       = 14;
  localparam int BASE_W      = 10;
  localparam int STEP_W      = 7;
  localparam int THR_W       = 11;
  localparam int LEVEL_W     = 4;
  localparam int CODE_W      = 8;
  localparam int NUM_THRESH  = 8;
  localparam int NUM_DIGITS  = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + WIN_LEN - 1) / WIN_LEN);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(425);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE = 1'b0,
    CFG_STEP = 1'b1
  } cfg_idx_t;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [CODE_W-1:0]   code_t;

  localparam code_t CODE_FULL  = 8'h36;
  localparam code_t CODE_HALF  = 8'h06;
  localparam code_t CODE_BLANK = 8'h00;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [STEP_W-1:0] step;
  } thr_cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

// ===== sv/avlm_if.sv =====
// Stream interfaces carrying sample words in and meter words out.
interface avlm_in_if;
  import avlm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface avlm_out_if;
  import avlm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_W-1:0]       mean_level;
  logic [LEVEL_W-1:0]        bar_count;
  code_t                     digit0_code;
  code_t                     digit1_code;
  code_t                     digit2_code;
  code_t                     digit3_code;
  modport source (output valid, output mean_level, output bar_count, output digit0_code,
                  output digit1_code, output digit2_code, output digit3_code, input ready);
  modport sink (input valid, input mean_level, input bar_count, input digit0_code,
                input digit1_code, input digit2_code, input digit3_code, output ready);
endinterface

// ===== sv/avlm_front.sv =====
// Front end: sample delay line and running window sum.
module avlm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  avlm_pkg::sample_t in_sample,
  input  logic              q_full,
  output avlm_pkg::q_wr_t   q_wr,
  output avlm_pkg::sum_t    q_wdata
);
  import avlm_pkg::*;

  sample_t win_r [WIN_LEN];
  sum_t    sum_r;
  sum_t    sum_nxt;
  logic    take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign sum_nxt  = sum_r - SUM_W'(win_r[WIN_LEN-1]) + SUM_W'(in_sample);

  assign q_wr.push = take;
  assign q_wr.full = q_full;
  assign q_wdata   = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= '0;
    end else if (take) begin
      sum_r    <= sum_nxt;
      win_r[0] <= in_sample;
      for (int i = 1; i < WIN_LEN; i++) win_r[i] <= win_r[i-1];
    end
  end

endmodule

// ===== sv/avlm_queue.sv =====
// Short queue of window sums between the front and back ends.
module avlm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  avlm_pkg::q_wr_t wr,
  input  avlm_pkg::sum_t  wdata,
  output logic            full,
  input  logic            pop,
  output avlm_pkg::q_rd_t rd,
  output avlm_pkg::sum_t  rdata
);
  import avlm_pkg::*;

  sum_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign rd.empty = (cnt_r == '0);
  assign rd.pop   = do_pop;
  assign do_pop   = pop && !rd.empty;
  assign do_push  = wr.push && !full;
  assign rdata    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + Q_CW'(do_push) - Q_CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== sv/avlm_back.sv =====
// Back end: window mean, threshold level and digit codes into the output register.
module avlm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  avlm_pkg::thr_cfg_t cfg,
  input  avlm_pkg::q_rd_t    q_rd,
  input  avlm_pkg::sum_t     q_rdata,
  output logic               q_pop,
  avlm_out_if.source         out_ch
);
  import avlm_pkg::*;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] mean;
  logic [THR_W-1:0]    thr [NUM_THRESH];
  logic [LEVEL_W-1:0]  level;
  logic [2:0]          full_cnt;
  code_t               code [NUM_DIGITS];
  logic                load;

  logic                valid_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [LEVEL_W-1:0]  level_r;
  code_t               code_r [NUM_DIGITS];

  assign prod = PROD_W'(q_rdata) * PROD_W'(RECIP);
  assign mean = prod[RECIP_SHIFT +: SAMPLE_W];

  always_comb begin
    level = '0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      thr[k] = THR_W'(cfg.base) + THR_W'(THR_W'(k) * THR_W'(cfg.step));
      if (thr[k] <= THR_W'(mean)) level = level + 1'b1;
    end
  end

  assign full_cnt = level[LEVEL_W-1:1];

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (3'(d) < full_cnt) code[d] = CODE_FULL;
      else if (3'(d) == full_cnt && level[0]) code[d] = CODE_HALF;
      else code[d] = CODE_BLANK;
    end
  end

  assign load  = !q_rd.empty && (!valid_r || out_ch.ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_r  <= mean;
      level_r <= level;
      for (int d = 0; d < NUM_DIGITS; d++) code_r[d] <= code[d];
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.mean_level  = mean_r;
  assign out_ch.bar_count   = level_r;
  assign out_ch.digit0_code = code_r[0];
  assign out_ch.digit1_code = code_r[1];
  assign out_ch.digit2_code = code_r[2];
  assign out_ch.digit3_code = code_r[3];

endmodule

// ===== sv/averaged_level_bar_meter.sv =====
// Top level of the averaged level bar meter.
// The meter takes one sample word per clock cycle while the queue is not full and gives one
// result word per sample once the output side takes it: the front end updates the ten-entry
// delay line and running sum at the accepting edge and queues the sum, and the back end turns
// it into the mean, bar level and digit codes through a reciprocal multiplier into the
// output register. A two-entry queue lets input and output stall independently.
// Threshold registers may be written only while the meter holds no word in flight.
module averaged_level_bar_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  avlm_in_if.sink                            in_ch,
  avlm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [avlm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [avlm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import avlm_pkg::*;

  thr_cfg_t cfg_r;
  q_wr_t    q_wr;
  q_rd_t    q_rd;
  sum_t     q_wdata, q_rdata;
  logic     q_full, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base <= BASE_RST;
      cfg_r.step <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_BASE: cfg_r.base <= cfg_wdata[BASE_W-1:0];
        CFG_STEP: cfg_r.step <= cfg_wdata[STEP_W-1:0];
        default:  ;
      endcase
    end
  end

  avlm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_sample(in_ch.sample),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata)
  );

  avlm_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rd   (q_rd),
    .rdata(q_rdata)
  );

  avlm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_rd   (q_rd),
    .q_rdata(q_rdata),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
